// ===== hw/rtl/gtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants of the tree object parser
// Byte classes, error codes, entry types, header text and known mode values.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int SIZE_FIELD_CHARS_DEF = 25;
  localparam int MODE_FIELD_CHARS_DEF = 10;
  localparam int ID_BYTES_DEF         = 20;

  localparam int HDR_LEN     = 5;
  localparam int SIZE_W      = 32;
  localparam int CNT_W       = 33;
  localparam int MODE_W      = 30;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [MODE_W-1:0] MODE_TREE    = 30'o040000;
  localparam logic [MODE_W-1:0] MODE_REG     = 30'o100644;
  localparam logic [MODE_W-1:0] MODE_EXEC    = 30'o100755;
  localparam logic [MODE_W-1:0] MODE_LINK    = 30'o120000;
  localparam logic [MODE_W-1:0] MODE_GITLINK = 30'o160000;

  typedef enum logic [2:0] {
    CLS_HEADER    = 3'd0,
    CLS_SIZE_DIG  = 3'd1,
    CLS_SIZE_NUL  = 3'd2,
    CLS_MODE_DIG  = 3'd3,
    CLS_MODE_SPC  = 3'd4,
    CLS_NAME      = 3'd5,
    CLS_NAME_NUL  = 3'd6,
    CLS_ID        = 3'd7
  } byte_class_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_HEADER    = 3'd1,
    ERR_SIZE      = 3'd2,
    ERR_MISMATCH  = 3'd3,
    ERR_MODE      = 3'd4,
    ERR_GITLINK   = 3'd5,
    ERR_UNKNOWN   = 3'd6,
    ERR_TRUNC     = 3'd7
  } err_code_t;

  typedef enum logic [1:0] {
    ET_TREE = 2'd0,
    ET_REG  = 2'd1,
    ET_EXEC = 2'd2,
    ET_LINK = 2'd3
  } entry_type_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } gtp_item_t;

  typedef struct packed {
    byte_class_t byte_class;
    logic [7:0]  byte_out;
    logic        entry_done;
    entry_type_t entry_type;
    err_code_t   error_code;
    logic        object_done;
  } gtp_result_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h74;
      3'd1: c = 8'h72;
      3'd2: c = 8'h65;
      3'd3: c = 8'h65;
      default: c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/gtp_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_in_reg: input register stage
// Captures one request per cycle while in_ready; holds it until parse takes it.
// ----------------------------------------------------------------------------
module gtp_in_reg
  import gtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gtp_item_t in_item,
  input  logic      take,
  output logic      valid,
  output gtp_item_t item
);

  logic      valid_r, valid_nxt;
  gtp_item_t item_r, item_nxt;

  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

// ===== hw/rtl/gtp_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_parse: tree object phase logic
// Holds the parse state and works out the result for the registered byte.
// ----------------------------------------------------------------------------
module gtp_parse
  import gtp_pkg::*;
#(
  parameter int SIZE_FIELD_CHARS = SIZE_FIELD_CHARS_DEF,
  parameter int MODE_FIELD_CHARS = MODE_FIELD_CHARS_DEF,
  parameter int ID_BYTES         = ID_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  gtp_item_t   item,
  output gtp_result_t res
);

  localparam int FC_M1  = (SIZE_FIELD_CHARS > ID_BYTES) ? SIZE_FIELD_CHARS : ID_BYTES;
  localparam int FC_M2  = (FC_M1 > MODE_FIELD_CHARS) ? FC_M1 : MODE_FIELD_CHARS;
  localparam int FC_MAX = (FC_M2 > HDR_LEN) ? FC_M2 : HDR_LEN;
  localparam int FC_W   = $clog2(FC_MAX + 1);

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SIZE   = 5'b00010,
    PH_MODE   = 5'b00100,
    PH_NAME   = 5'b01000,
    PH_ID     = 5'b10000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  err_code_t         err_r, err_nxt;
  logic              seen_r, seen_nxt;

  logic [7:0]        b;
  logic              is_dec, is_oct;
  logic [35:0]       size_acc;
  err_code_t         flag_code;
  err_code_t         err_out;
  byte_class_t       cls;
  entry_type_t       etype;
  logic              done;
  logic              mode_ok;
  logic              size_ended, clean;

  assign b        = item.byte_in;
  assign is_dec   = b inside {[CH_ZERO:CH_NINE]};
  assign is_oct   = b inside {[CH_ZERO:CH_SEVEN]};
  assign size_acc = {1'b0, size_r, 3'b000} + {3'b000, size_r, 1'b0} + {32'd0, b[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    size_nxt  = size_r;
    cnt_nxt   = cnt_r;
    mode_nxt  = mode_r;
    err_nxt   = err_r;
    seen_nxt  = seen_r;
    flag_code = ERR_NONE;
    cls       = CLS_HEADER;
    etype     = ET_TREE;
    done      = 1'b0;
    mode_ok   = 1'b1;

    if ((phase_r inside {PH_MODE, PH_NAME, PH_ID}) && cnt_r != '1) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    case (phase_r)
      PH_HEADER: begin
        cls = CLS_HEADER;
        if (b != hdr_char(fc_r[2:0])) begin
          flag_code = ERR_HEADER;
        end
        if (fc_r >= FC_W'(HDR_LEN - 1)) begin
          phase_nxt = PH_SIZE;
          fc_nxt    = '0;
        end else begin
          fc_nxt = fc_r + FC_W'(1);
        end
      end
      PH_SIZE: begin
        if (b == CH_NUL) begin
          cls = CLS_SIZE_NUL;
          if (!seen_r) begin
            flag_code = ERR_SIZE;
          end
          phase_nxt = PH_MODE;
          fc_nxt    = '0;
          mode_nxt  = '0;
        end else begin
          cls = CLS_SIZE_DIG;
          if (fc_r >= FC_W'(SIZE_FIELD_CHARS)) begin
            flag_code = ERR_SIZE;
          end else begin
            fc_nxt = fc_r + FC_W'(1);
          end
          if (is_dec) begin
            seen_nxt = 1'b1;
            if (size_acc[35:32] != 4'd0) begin
              flag_code = ERR_SIZE;
            end else begin
              size_nxt = size_acc[31:0];
            end
          end else begin
            flag_code = ERR_SIZE;
          end
        end
      end
      PH_MODE: begin
        if (b == CH_SPACE) begin
          cls = CLS_MODE_SPC;
          if (fc_r == '0) begin
            flag_code = ERR_MODE;
          end
          phase_nxt = PH_NAME;
          fc_nxt    = '0;
        end else begin
          cls = CLS_MODE_DIG;
          if (fc_r >= FC_W'(MODE_FIELD_CHARS)) begin
            flag_code = ERR_MODE;
          end else begin
            fc_nxt = fc_r + FC_W'(1);
          end
          if (is_oct) begin
            mode_nxt = {mode_r[MODE_W-4:0], b[2:0]};
          end else begin
            flag_code = ERR_MODE;
          end
        end
      end
      PH_NAME: begin
        if (b == CH_NUL) begin
          cls       = CLS_NAME_NUL;
          phase_nxt = PH_ID;
          fc_nxt    = '0;
        end else begin
          cls = CLS_NAME;
        end
      end
      PH_ID: begin
        cls = CLS_ID;
        if (fc_r >= FC_W'(ID_BYTES - 1)) begin
          if (mode_r == MODE_TREE) begin
            etype = ET_TREE;
          end else if (mode_r == MODE_REG) begin
            etype = ET_REG;
          end else if (mode_r == MODE_EXEC) begin
            etype = ET_EXEC;
          end else if (mode_r == MODE_LINK) begin
            etype = ET_LINK;
          end else if (mode_r == MODE_GITLINK) begin
            flag_code = ERR_GITLINK;
            mode_ok   = 1'b0;
          end else begin
            flag_code = ERR_UNKNOWN;
            mode_ok   = 1'b0;
          end
          if (mode_ok && err_r == ERR_NONE) begin
            done = 1'b1;
          end else begin
            etype = ET_TREE;
          end
          phase_nxt = PH_MODE;
          fc_nxt    = '0;
          mode_nxt  = '0;
        end else begin
          fc_nxt = fc_r + FC_W'(1);
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
        fc_nxt    = '0;
      end
    endcase

    if (err_r == ERR_NONE && flag_code != ERR_NONE) begin
      err_nxt = flag_code;
    end
  end

  assign size_ended = phase_nxt inside {PH_MODE, PH_NAME, PH_ID};
  assign clean      = (phase_nxt == PH_MODE) && (fc_nxt == '0);

  always_comb begin
    err_out = err_nxt;
    if (item.last_byte) begin
      if (err_nxt == ERR_HEADER || err_nxt == ERR_SIZE) begin
        err_out = err_nxt;
      end else if (size_ended && cnt_nxt != {1'b0, size_nxt}) begin
        err_out = ERR_MISMATCH;
      end else if (err_nxt == ERR_NONE && !clean) begin
        err_out = ERR_TRUNC;
      end
    end
  end

  assign res.byte_class  = cls;
  assign res.byte_out    = b;
  assign res.entry_done  = done;
  assign res.entry_type  = etype;
  assign res.error_code  = err_out;
  assign res.object_done = item.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      fc_r    <= '0;
      size_r  <= '0;
      cnt_r   <= '0;
      mode_r  <= '0;
      err_r   <= ERR_NONE;
      seen_r  <= 1'b0;
    end else if (step) begin
      if (item.last_byte) begin
        phase_r <= PH_HEADER;
        fc_r    <= '0;
        size_r  <= '0;
        cnt_r   <= '0;
        mode_r  <= '0;
        err_r   <= ERR_NONE;
        seen_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        fc_r    <= fc_nxt;
        size_r  <= size_nxt;
        cnt_r   <= cnt_nxt;
        mode_r  <= mode_nxt;
        err_r   <= err_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  a_done_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.entry_done && !res.object_done |-> res.error_code == ERR_NONE)
    else $error("entry_done raised with an error pending");

  a_done_on_id: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.entry_done |-> res.byte_class == CLS_ID)
    else $error("entry_done outside an id byte");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> phase_r == PH_HEADER && fc_r == '0 && cnt_r == '0
      && err_r == ERR_NONE)
    else $error("parser did not restart after the last byte");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    step && !item.last_byte && err_r != ERR_NONE |=> err_r == $past(err_r))
    else $error("latched error changed inside an object");

endmodule

// ===== hw/rtl/gtp_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_out_reg: result register stage
// Holds one result until the receiver takes it; frees itself on the take.
// ----------------------------------------------------------------------------
module gtp_out_reg
  import gtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  gtp_result_t res_in,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output gtp_result_t res
);

  logic        valid_r, valid_nxt;
  gtp_result_t res_r, res_nxt;

  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (space) begin
      valid_nxt = load;
      if (load) begin
        res_nxt = res_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== hw/rtl/git_tree_object_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// git_tree_object_parser_unit: streaming tree object parser
// One byte of a serialized tree object enters per request; each request gives
// one result with the byte's class, the echoed byte and the parse status.
//
// Input channel in_*: in_byte_in and in_last_byte, marking the object's end.
// Result channel out_*: byte class, byte, entry_done/entry_type on the last
// id byte of a good entry, the latched error code (final when
// out_object_done is high) and out_object_done.
// Path: an accepted request is registered in the input register, then its
// result in the result register, where out_valid rises.
// Throughput: one byte per cycle while out_ready does not hold the result
// register, set by the single pass of phase logic between the two registers.
// Reset: the parser starts in the header phase with no error latched; it
// also returns there on its own after each byte marked last.
// Stall: while out_ready is low the result register holds, the input register
// takes one more request and then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module git_tree_object_parser_unit
  import gtp_pkg::*;
#(
  parameter int SIZE_FIELD_CHARS = SIZE_FIELD_CHARS_DEF,
  parameter int MODE_FIELD_CHARS = MODE_FIELD_CHARS_DEF,
  parameter int ID_BYTES         = ID_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_byte_class,
  output logic [7:0] out_byte_out,
  output logic       out_entry_done,
  output logic [1:0] out_entry_type,
  output logic [2:0] out_error_code,
  output logic       out_object_done
);

  gtp_item_t   in_item, s1_item;
  gtp_result_t parse_res, out_res;
  logic        s1_valid, out_space, take;

  assign in_item.byte_in   = in_byte_in;
  assign in_item.last_byte = in_last_byte;
  assign take              = s1_valid && out_space;

  gtp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  gtp_parse #(
    .SIZE_FIELD_CHARS (SIZE_FIELD_CHARS),
    .MODE_FIELD_CHARS (MODE_FIELD_CHARS),
    .ID_BYTES         (ID_BYTES)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (take),
    .item  (s1_item),
    .res   (parse_res)
  );

  gtp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .res_in    (parse_res),
    .space     (out_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (out_res)
  );

  assign out_byte_class  = out_res.byte_class;
  assign out_byte_out    = out_res.byte_out;
  assign out_entry_done  = out_res.entry_done;
  assign out_entry_type  = out_res.entry_type;
  assign out_error_code  = out_res.error_code;
  assign out_object_done = out_res.object_done;

endmodule
